### design/dmhq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the deadline min-heap queue.
// No dependencies; used by every other file of the block.

package dmhq_pkg;

  localparam int CAPACITY      = 1024;
  localparam int ADDR_W        = $clog2(CAPACITY);
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  // index math (2*pos+2) needs headroom above the address width
  localparam int IDX_W         = ADDR_W + 2;
  localparam int COUNT_FIELD_W = 11;
  localparam int KEY_W         = 64;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_NOTDUE = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMP_DUE,    // now < root deadline
    CMP_UP,     // parent < moving entry
    CMP_RIGHT,  // right child < left child
    CMP_DOWN    // moving entry < chosen child
  } cmp_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LAST,
    S_DN_CHECK,
    S_DN_LC,
    S_DN_RC,
    S_DN_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        [KEY_W-1:0] expire;
    logic        [KEY_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic        [1:0]       kind;
    logic signed [KEY_W-1:0] new_value;
    logic signed [KEY_W-1:0] new_expire;
    logic signed [KEY_W-1:0] now;
  } in_t;

  typedef struct packed {
    logic        [1:0]               status;
    logic                            popped;
    logic signed [KEY_W-1:0]         out_value;
    logic signed [KEY_W-1:0]         out_expire;
    logic        [COUNT_FIELD_W-1:0] entry_count;
    logic                            top_valid;
    logic signed [KEY_W-1:0]         top_value;
    logic signed [KEY_W-1:0]         top_expire;
  } out_t;

endpackage

### design/dmhq_cmp.sv
`timescale 1ns / 1ps
// Shared signed 64-bit less-than unit with operand selection.
// Depends on dmhq_pkg.

module dmhq_cmp (
  input  dmhq_pkg::cmp_sel_e             sel_i,
  input  logic [dmhq_pkg::KEY_W-1:0]     now_i,
  input  logic [dmhq_pkg::KEY_W-1:0]     root_exp_i,
  input  logic [dmhq_pkg::KEY_W-1:0]     rdata_exp_i,
  input  logic [dmhq_pkg::KEY_W-1:0]     item_exp_i,
  input  logic [dmhq_pkg::KEY_W-1:0]     child_exp_i,
  output logic                           lt_o
);

  logic signed [dmhq_pkg::KEY_W-1:0] op_a;
  logic signed [dmhq_pkg::KEY_W-1:0] op_b;

  always_comb begin
    case (sel_i)
      dmhq_pkg::CMP_DUE: begin
        op_a = now_i;
        op_b = root_exp_i;
      end
      dmhq_pkg::CMP_UP: begin
        op_a = rdata_exp_i;
        op_b = item_exp_i;
      end
      dmhq_pkg::CMP_RIGHT: begin
        op_a = rdata_exp_i;
        op_b = child_exp_i;
      end
      dmhq_pkg::CMP_DOWN: begin
        op_a = item_exp_i;
        op_b = child_exp_i;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign lt_o = op_a < op_b;

endmodule

### design/dmhq_ctrl.sv
`timescale 1ns / 1ps
// Heap sequencer: entry memory, root copy, fill count and sift-up/sift-down steps.
// Depends on dmhq_pkg and dmhq_cmp.

module dmhq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  dmhq_pkg::in_t    in_i,
  output logic             idle_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output dmhq_pkg::out_t   res_o
);

  localparam int AW = dmhq_pkg::ADDR_W;
  localparam int CW = dmhq_pkg::CNT_W;
  localparam int IW = dmhq_pkg::IDX_W;

  dmhq_pkg::state_e   state_q, state_d;
  dmhq_pkg::in_t      in_q;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [AW-1:0]      cidx_q, cidx_d;
  dmhq_pkg::entry_t   item_q, item_d;
  dmhq_pkg::entry_t   child_q, child_d;
  dmhq_pkg::entry_t   root_q, root_d;
  dmhq_pkg::entry_t   pop_ent_q, pop_ent_d;
  logic [1:0]         stat_q, stat_d;
  logic               popped_q, popped_d;

  dmhq_pkg::entry_t   mem_q [dmhq_pkg::CAPACITY];
  dmhq_pkg::entry_t   rdata_q;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  dmhq_pkg::entry_t   mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;

  dmhq_pkg::cmp_sel_e cmp_sel;
  logic               cmp_lt;

  logic [AW-1:0]      pos_m1;
  logic [AW-1:0]      up_idx;
  logic [IW-1:0]      lc_w;
  logic [IW-1:0]      rc_w;
  logic [IW-1:0]      half_w;

  assign pos_m1 = pos_q - AW'(1);
  assign up_idx = pos_m1 >> 1;
  assign lc_w   = (IW'(pos_q) << 1) + IW'(1);
  assign rc_w   = lc_w + IW'(1);
  assign half_w = IW'(cnt_q) >> 1;

  dmhq_cmp u_cmp (
    .sel_i       (cmp_sel),
    .now_i       (in_q.now),
    .root_exp_i  (root_q.expire),
    .rdata_exp_i (rdata_q.expire),
    .item_exp_i  (item_q.expire),
    .child_exp_i (child_q.expire),
    .lt_o        (cmp_lt)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    cidx_d      = cidx_q;
    item_d      = item_q;
    child_d     = child_q;
    pop_ent_d   = pop_ent_q;
    stat_d      = stat_q;
    popped_d    = popped_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = item_q;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    cmp_sel     = dmhq_pkg::CMP_UP;
    res_valid_o = 1'b0;

    case (state_q)
      dmhq_pkg::S_IDLE: begin
        if (start_i) state_d = dmhq_pkg::S_START;
      end
      dmhq_pkg::S_START: begin
        stat_d    = dmhq_pkg::ST_DONE;
        popped_d  = 1'b0;
        pop_ent_d = '0;
        state_d   = dmhq_pkg::S_DONE;
        case (dmhq_pkg::kind_e'(in_q.kind))
          dmhq_pkg::KIND_INSERT: begin
            item_d.expire = in_q.new_expire;
            item_d.value  = in_q.new_value;
            if (cnt_q == CW'(dmhq_pkg::CAPACITY)) begin
              stat_d = dmhq_pkg::ST_FULL;
            end else begin
              pos_d   = AW'(cnt_q);
              cnt_d   = cnt_q + CW'(1);
              state_d = dmhq_pkg::S_UP_RD;
            end
          end
          dmhq_pkg::KIND_POP: begin
            cmp_sel = dmhq_pkg::CMP_DUE;
            if (cnt_q == '0) begin
              stat_d = dmhq_pkg::ST_EMPTY;
            end else if (cmp_lt) begin
              stat_d = dmhq_pkg::ST_NOTDUE;
            end else begin
              popped_d  = 1'b1;
              pop_ent_d = root_q;
              cnt_d     = cnt_q - CW'(1);
              state_d   = dmhq_pkg::S_POP_RD;
            end
          end
          dmhq_pkg::KIND_CLEAR: begin
            cnt_d = '0;
          end
          default: ;
        endcase
      end
      dmhq_pkg::S_UP_RD: begin
        if (pos_q == '0) begin
          mem_we  = 1'b1;
          state_d = dmhq_pkg::S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = up_idx;
          state_d   = dmhq_pkg::S_UP_CMP;
        end
      end
      dmhq_pkg::S_UP_CMP: begin
        // equal keys keep climbing; only a strictly smaller parent stops it
        cmp_sel = dmhq_pkg::CMP_UP;
        mem_we  = 1'b1;
        if (cmp_lt) begin
          state_d = dmhq_pkg::S_DONE;
        end else begin
          mem_wdata = rdata_q;
          pos_d     = up_idx;
          state_d   = dmhq_pkg::S_UP_RD;
        end
      end
      dmhq_pkg::S_POP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(cnt_q);
        state_d   = dmhq_pkg::S_POP_LAST;
      end
      dmhq_pkg::S_POP_LAST: begin
        item_d  = rdata_q;
        pos_d   = '0;
        state_d = dmhq_pkg::S_DN_CHECK;
      end
      dmhq_pkg::S_DN_CHECK: begin
        if (IW'(pos_q) < half_w) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(lc_w);
          state_d   = dmhq_pkg::S_DN_LC;
        end else begin
          mem_we  = 1'b1;
          state_d = dmhq_pkg::S_DONE;
        end
      end
      dmhq_pkg::S_DN_LC: begin
        child_d = rdata_q;
        cidx_d  = AW'(lc_w);
        if (rc_w < IW'(cnt_q)) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(rc_w);
          state_d   = dmhq_pkg::S_DN_RC;
        end else begin
          state_d = dmhq_pkg::S_DN_CMP;
        end
      end
      dmhq_pkg::S_DN_RC: begin
        // left child wins a tie
        cmp_sel = dmhq_pkg::CMP_RIGHT;
        if (cmp_lt) begin
          child_d = rdata_q;
          cidx_d  = AW'(rc_w);
        end
        state_d = dmhq_pkg::S_DN_CMP;
      end
      dmhq_pkg::S_DN_CMP: begin
        cmp_sel = dmhq_pkg::CMP_DOWN;
        mem_we  = 1'b1;
        if (cmp_lt) begin
          state_d = dmhq_pkg::S_DONE;
        end else begin
          mem_wdata = child_q;
          pos_d     = cidx_q;
          state_d   = dmhq_pkg::S_DN_CHECK;
        end
      end
      dmhq_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = dmhq_pkg::S_IDLE;
      end
      default: state_d = dmhq_pkg::S_IDLE;
    endcase
  end

  // root kept in flops so every result can report the top without a read
  always_comb begin
    root_d = root_q;
    if (mem_we && mem_waddr == '0) root_d = mem_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmhq_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) in_q <= in_i;
    pos_q     <= pos_d;
    cidx_q    <= cidx_d;
    item_q    <= item_d;
    child_q   <= child_d;
    root_q    <= root_d;
    pop_ent_q <= pop_ent_d;
    stat_q    <= stat_d;
    popped_q  <= popped_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  assign idle_o = (state_q == dmhq_pkg::S_IDLE);

  always_comb begin
    res_o             = '0;
    res_o.status      = stat_q;
    res_o.popped      = popped_q;
    res_o.out_value   = pop_ent_q.value;
    res_o.out_expire  = pop_ent_q.expire;
    res_o.entry_count = dmhq_pkg::COUNT_FIELD_W'(cnt_q);
    res_o.top_valid   = (cnt_q != '0);
    if (cnt_q != '0) begin
      res_o.top_value  = root_q.value;
      res_o.top_expire = root_q.expire;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(dmhq_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dmhq_pkg::S_IDLE || state_q == dmhq_pkg::S_DONE) |-> !mem_we)
    else $error("heap write outside an active transaction");

  a_pop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.popped) |-> (res_o.status == dmhq_pkg::ST_DONE))
    else $error("pop reported with a failing status");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_o)))
    else $error("pending result changed before handoff");

endmodule

### design/deadline_min_heap_queue_unit.sv
`timescale 1ns / 1ps
// Top level of the deadline min-heap queue: input handshake and output register.
// Depends on dmhq_pkg and dmhq_ctrl.

// Holds up to 1024 entries (signed 64-bit deadline plus 64-bit payload) in a
// binary min-heap kept in a single-port-write, single-port-read memory with a
// registered read. One transaction is processed at a time; in_stall_o is high
// from acceptance until the result moves into the output register, which lets
// the next transaction be accepted while a result still waits downstream.
// Every read and every deadline compare goes through one shared memory port
// and one 64-bit comparator, so latency follows the heap depth for insert and
// pop (a pop leaves at most 1023 entries, so the descent stops one level short),
// while clear, pop on an empty heap, pop not yet due and insert into a full heap
// skip the heap walk.
// No clearing pass is needed after reset; only slots below the fill count are
// ever read.

module deadline_min_heap_queue_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dmhq_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dmhq_pkg::out_t out_data_o
);

  logic           start;
  logic           idle;
  logic           res_valid;
  logic           res_load;
  dmhq_pkg::out_t res;

  logic           out_valid_q, out_valid_d;
  dmhq_pkg::out_t out_data_q;

  assign in_stall_o = !idle;
  assign start      = in_valid_i && idle;

  dmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .in_i        (in_data_i),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_load),
    .res_o       (res)
  );

  // output slot frees up when empty or when its transaction leaves this cycle
  assign res_load = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) out_data_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### dv/deadline_min_heap_queue_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for deadline_min_heap_queue_unit: directed and random
// insert/pop/clear traffic, checked against an in-bench heap predictor.
// Depends on dmhq_pkg and the deadline_min_heap_queue_unit RTL.

module deadline_min_heap_queue_unit_tb;

  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam logic [63:0] KEY_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KEY_MIN     = 64'h8000_0000_0000_0000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 60;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid;
  logic           in_stall;
  dmhq_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  dmhq_pkg::out_t out_data;

  deadline_min_heap_queue_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // predictor state
  dmhq_pkg::entry_t heap_mem [dmhq_pkg::CAPACITY];
  int               heap_fill;

  dmhq_pkg::in_t  pending_q  [$];
  dmhq_pkg::out_t expected_q [$];

  int send_idle_pct;
  int recv_idle_pct;
  logic hold_req;
  logic hold_armed;
  int   hold_left;

  int mismatches;
  int n_results;
  int n_popped;
  int n_full;
  int n_notdue;
  int cycle_count;

  function automatic dmhq_pkg::out_t heap_apply(input dmhq_pkg::in_t item);
    dmhq_pkg::out_t   res;
    dmhq_pkg::entry_t mv;
    int     pos;
    int     up;
    int     c;
    int     half;
    res = '0;
    res.status = dmhq_pkg::ST_DONE;
    if (item.kind == dmhq_pkg::KIND_INSERT) begin
      if (heap_fill >= dmhq_pkg::CAPACITY) begin
        res.status = dmhq_pkg::ST_FULL;
      end else begin
        mv.value  = item.new_value;
        mv.expire = item.new_expire;
        pos = heap_fill;
        heap_fill++;
        // equal keys keep climbing; only a strictly smaller parent stops it
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if ($signed(heap_mem[up].expire) < $signed(mv.expire)) break;
          heap_mem[pos] = heap_mem[up];
          pos = up;
        end
        heap_mem[pos] = mv;
      end
    end else if (item.kind == dmhq_pkg::KIND_POP) begin
      if (heap_fill == 0) begin
        res.status = dmhq_pkg::ST_EMPTY;
      end else if ($signed(item.now) < $signed(heap_mem[0].expire)) begin
        res.status = dmhq_pkg::ST_NOTDUE;
      end else begin
        res.popped     = 1'b1;
        res.out_value  = heap_mem[0].value;
        res.out_expire = heap_mem[0].expire;
        heap_fill--;
        mv   = heap_mem[heap_fill];
        half = heap_fill / 2;
        pos  = 0;
        while (pos < half) begin
          c = 2 * pos + 1;
          if (c + 1 < heap_fill &&
              $signed(heap_mem[c+1].expire) < $signed(heap_mem[c].expire)) c = c + 1;
          if ($signed(mv.expire) < $signed(heap_mem[c].expire)) break;
          heap_mem[pos] = heap_mem[c];
          pos = c;
        end
        heap_mem[pos] = mv;
      end
    end else if (item.kind == dmhq_pkg::KIND_CLEAR) begin
      heap_fill = 0;
    end
    res.entry_count = heap_fill[dmhq_pkg::COUNT_FIELD_W-1:0];
    if (heap_fill > 0) begin
      res.top_valid  = 1'b1;
      res.top_value  = heap_mem[0].value;
      res.top_expire = heap_mem[0].expire;
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // deadline mix: wide random, small clustered values for ties, near the extremes, below 2^32
  function automatic logic [63:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return rand64();
    if (sel < 75) return 64'($signed($urandom_range(0, 15)) - 8);
    if (sel < 85) return KEY_MAX - 64'($urandom_range(0, 3));
    if (sel < 95) return KEY_MIN + 64'($urandom_range(0, 3));
    return {32'd0, $urandom};
  endfunction

  task automatic queue_item(input logic [1:0] k, input logic [63:0] v, input logic [63:0] e,
                            input logic [63:0] t);
    dmhq_pkg::in_t it;
    it.kind       = k;
    it.new_value  = v;
    it.new_expire = e;
    it.now        = t;
    pending_q.push_back(it);
  endtask

  task automatic queue_pop_random();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) queue_item(dmhq_pkg::KIND_POP, rand64(), rand64(), pick_key());
    else if (sel < 70) queue_item(dmhq_pkg::KIND_POP, rand64(), rand64(), KEY_MAX);
    else queue_item(dmhq_pkg::KIND_POP, rand64(), rand64(), rand64());
  endtask

  task automatic queue_random_mixed();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 52) queue_item(dmhq_pkg::KIND_INSERT, rand64(), pick_key(), rand64());
    else if (sel < 92) queue_pop_random();
    else if (sel < 96) queue_item(dmhq_pkg::KIND_CLEAR, rand64(), rand64(), rand64());
    else queue_item(KIND_UNUSED, rand64(), rand64(), rand64());
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s mismatch, expected %h, got %h", n_results, name, want, got);
    end
  endtask

  // driver: predicts each accepted transaction, then offers the next pending item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(heap_apply(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_armed <= 1'b0;
    end else if (hold_req && !hold_armed) begin
      hold_left  <= HOLD_CYCLES;
      hold_armed <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: compares each accepted result with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d: no transaction was expected", n_results);
        end else begin
          check_field("status",      64'(out_data.status),      64'(expected_q[0].status));
          check_field("popped",      64'(out_data.popped),      64'(expected_q[0].popped));
          check_field("out_value",   out_data.out_value,        expected_q[0].out_value);
          check_field("out_expire",  out_data.out_expire,       expected_q[0].out_expire);
          check_field("entry_count", 64'(out_data.entry_count), 64'(expected_q[0].entry_count));
          check_field("top_valid",   64'(out_data.top_valid),   64'(expected_q[0].top_valid));
          check_field("top_value",   out_data.top_value,        expected_q[0].top_value);
          check_field("top_expire",  out_data.top_expire,       expected_q[0].top_expire);
          if (expected_q[0].popped) n_popped++;
          if (expected_q[0].status == dmhq_pkg::ST_FULL) n_full++;
          if (expected_q[0].status == dmhq_pkg::ST_NOTDUE) n_notdue++;
          void'(expected_q.pop_front());
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_q.size() + pending_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(negedge clk_i);
  endtask

  initial begin
    heap_fill     = 0;
    mismatches    = 0;
    n_results     = 0;
    n_popped      = 0;
    n_full        = 0;
    n_notdue      = 0;
    cycle_count   = 0;
    send_idle_pct = 17;
    recv_idle_pct = 62;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty heap cases, unused kind, extreme keys and payloads, ties, due boundary
    queue_item(dmhq_pkg::KIND_POP,    rand64(), rand64(), rand64());
    queue_item(KIND_UNUSED,           KEY_MAX,  KEY_MIN,  KEY_MAX);
    queue_item(dmhq_pkg::KIND_CLEAR,  KEY_MIN,  KEY_MAX,  KEY_MIN);
    queue_item(dmhq_pkg::KIND_INSERT, KEY_MAX,  64'd0,    KEY_MIN);
    queue_item(dmhq_pkg::KIND_INSERT, KEY_MIN,  '1,       KEY_MAX);
    queue_item(dmhq_pkg::KIND_INSERT, 64'd0,    KEY_MAX,  rand64());
    queue_item(dmhq_pkg::KIND_INSERT, '1,       KEY_MIN,  rand64());
    queue_item(dmhq_pkg::KIND_INSERT, 64'h55AA, KEY_MIN,  rand64());
    queue_item(dmhq_pkg::KIND_POP,    rand64(), rand64(), KEY_MIN);
    queue_item(dmhq_pkg::KIND_POP,    rand64(), rand64(), KEY_MIN);
    queue_item(dmhq_pkg::KIND_POP,    rand64(), rand64(), 64'hFFFF_FFFF_FFFF_FFFE);
    queue_item(dmhq_pkg::KIND_POP,    rand64(), rand64(), '1);
    queue_item(KIND_UNUSED,           rand64(), rand64(), rand64());
    queue_item(dmhq_pkg::KIND_INSERT, 64'd1,    64'd5,    rand64());
    queue_item(dmhq_pkg::KIND_INSERT, 64'd2,    64'd5,    rand64());
    queue_item(dmhq_pkg::KIND_INSERT, 64'd3,    64'd5,    rand64());
    queue_item(dmhq_pkg::KIND_INSERT, 64'd4,    64'd4,    rand64());
    queue_item(dmhq_pkg::KIND_POP,    rand64(), rand64(), 64'd3);
    queue_item(dmhq_pkg::KIND_POP,    rand64(), rand64(), KEY_MAX);
    queue_item(dmhq_pkg::KIND_POP,    rand64(), rand64(), KEY_MAX);
    queue_item(dmhq_pkg::KIND_CLEAR,  rand64(), rand64(), rand64());
    queue_item(dmhq_pkg::KIND_POP,    rand64(), rand64(), KEY_MAX);
    wait_idle();

    // receiver holds off while the sender keeps offering, so the input backs up
    hold_req = 1'b1;
    repeat (80) queue_random_mixed();
    wait_idle();

    send_idle_pct = 62;
    recv_idle_pct = 17;
    repeat (80) queue_random_mixed();
    wait_idle();

    // fill to capacity, overflow, then partial drain
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_item(dmhq_pkg::KIND_CLEAR, rand64(), rand64(), rand64());
    repeat (dmhq_pkg::CAPACITY + 4)
      queue_item(dmhq_pkg::KIND_INSERT, rand64(), pick_key(), rand64());
    repeat (60) queue_pop_random();
    repeat (10) queue_random_mixed();
    wait_idle();

    repeat (DRAIN_WAIT) @(negedge clk_i);
    $display("%0d transactions checked: %0d pops, %0d not due, %0d dropped on a full heap",
             n_results, n_popped, n_notdue, n_full);
    $display("covered empty, tie, signed-extreme and full-capacity cases under back-pressure");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
